### rtl/kpd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kpd_pkg: shared types and constants for the keypad scanner
// Transaction payloads, the 4x4 character map and the matrix geometry.
// ----------------------------------------------------------------------------
package kpd_pkg;

	// Matrix geometry used for the scan order, bit index = col * KEY_ROWS + row.
	localparam int KEY_ROWS = 4;
	localparam int KEY_COLS = 4;
	localparam int MAP_DIM  = 4;
	localparam int KEY_BITS = 16;

	localparam int CHAR_W    = 7;
	localparam int TIME_W    = 32;
	localparam int DEBOUNCE_W = 16;

	localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET = 16'd25;
	localparam logic [CHAR_W-1:0]     NO_KEY         = 7'd0;

	// Character map, indexed [row][col].
	localparam logic [CHAR_W-1:0] KPD_MAP [MAP_DIM][MAP_DIM] = '{
		'{7'h31, 7'h32, 7'h33, 7'h41},  // 1 2 3 A
		'{7'h34, 7'h35, 7'h36, 7'h42},  // 4 5 6 B
		'{7'h37, 7'h38, 7'h39, 7'h43},  // 7 8 9 C
		'{7'h2A, 7'h30, 7'h23, 7'h44}   // * 0 # D
	};

	// One poll of the keypad.
	typedef struct packed {
		logic                int_event;
		logic                int_level;
		logic [KEY_BITS-1:0] key_lines;
		logic [TIME_W-1:0]   now_ms;
	} kpd_in_t;

	// One scan result.
	typedef struct packed {
		logic [CHAR_W-1:0] key_char;
		logic              scan_pending;
	} kpd_out_t;

endpackage : kpd_pkg
`default_nettype wire

### rtl/matrix_keypad_scan_debounce.sv
`default_nettype none
// ----------------------------------------------------------------------------
// matrix_keypad_scan_debounce: 4x4 keypad scanner with debounce
// Input register, single-pass decode and debounce, result register.
// ----------------------------------------------------------------------------
// Each input transaction is one keypad poll and produces exactly one result
// transaction. The block accepts one poll per clock cycle unless in_stall is
// high; an accepted poll passes through the input register and then, across
// the single-pass decode/debounce logic, into the result register. While a
// result is stalled, one further poll may wait in the input register. The
// debounce time is written through cfg_wr_en/cfg_wr_data, by the user only
// while the block is idle; the block does not enforce this. It resets to 25.
module matrix_keypad_scan_debounce (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_wr_en,
	input  wire logic [kpd_pkg::DEBOUNCE_W-1:0] cfg_wr_data,
	input  wire logic                           in_valid,
	output logic                                in_stall,
	input  wire kpd_pkg::kpd_in_t               in_data,
	output logic                                out_valid,
	input  wire logic                           out_stall,
	output kpd_pkg::kpd_out_t                   out_data
);
	import kpd_pkg::*;

	logic              valid_s1;
	kpd_in_t           data_s1;
	logic              advance;
	logic [CHAR_W-1:0] key;
	kpd_out_t          result;

	// A transaction moves on when the result register is empty or being taken.
	assign advance  = !out_valid || !out_stall;
	assign in_stall = valid_s1 && !advance;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			data_s1 <= in_data;
		end
	end

	kpd_key_decode u_decode (
		.key_lines (data_s1.key_lines),
		.key_char  (key)
	);

	kpd_debounce u_debounce (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.fire        (valid_s1 && advance),
		.int_event   (data_s1.int_event),
		.int_level   (data_s1.int_level),
		.now_ms      (data_s1.now_ms),
		.key         (key),
		.result      (result)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (advance) begin
			out_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			out_data <= result;
		end
	end

	// A delivered key character always comes with the pending flag set.
	a_key_implies_pending: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.key_char == NO_KEY || out_data.scan_pending))
		else $error("key character delivered without pending flag");

	// An accepted poll always lands in the input register.
	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> valid_s1)
		else $error("accepted transaction lost at the input register");

	// A waiting poll moves into the result register once the output frees up.
	a_s1_drains: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && advance |=> out_valid)
		else $error("transaction lost between input and result register");

endmodule : matrix_keypad_scan_debounce
`default_nettype wire

### rtl/kpd_key_decode.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kpd_key_decode: first pressed key to character
// Priority encoder over the active-low matrix samples in column-then-row
// order, followed by the character map lookup.
// ----------------------------------------------------------------------------
module kpd_key_decode (
	input  wire logic [kpd_pkg::KEY_BITS-1:0] key_lines,
	output logic      [kpd_pkg::CHAR_W-1:0]   key_char
);
	import kpd_pkg::*;

	logic found;

	// Scan columns, then rows within a column; the first low sample wins.
	// Positions outside the sample word or the character map never count.
	always_comb begin
		found    = 1'b0;
		key_char = NO_KEY;
		for (int c = 0; c < KEY_COLS; c++) begin
			for (int r = 0; r < KEY_ROWS; r++) begin
				if (!found && (c * KEY_ROWS + r) < KEY_BITS && r < MAP_DIM && c < MAP_DIM) begin
					if (!key_lines[$clog2(KEY_BITS)'(c * KEY_ROWS + r)]) begin
						found    = 1'b1;
						key_char = KPD_MAP[r][c];
					end
				end
			end
		end
	end

endmodule : kpd_key_decode
`default_nettype wire

### rtl/kpd_debounce.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kpd_debounce: pending flag, debounce timer and key acceptance
// Holds the scanner state and the debounce register, and computes one
// result per transaction that is handed to the result register.
// ----------------------------------------------------------------------------
module kpd_debounce (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_wr_en,
	input  wire logic [kpd_pkg::DEBOUNCE_W-1:0] cfg_wr_data,
	input  wire logic                           fire,
	input  wire logic                           int_event,
	input  wire logic                           int_level,
	input  wire logic [kpd_pkg::TIME_W-1:0]     now_ms,
	input  wire logic [kpd_pkg::CHAR_W-1:0]     key,
	output kpd_pkg::kpd_out_t                   result
);
	import kpd_pkg::*;

	logic [DEBOUNCE_W-1:0] debounce_q;
	logic                  pending_q;
	logic [CHAR_W-1:0]     raw_key_q;
	logic [TIME_W-1:0]     change_time_q;
	logic [CHAR_W-1:0]     stable_key_q;

	logic                  pend_eff;
	logic                  changed;
	logic [TIME_W-1:0]     change_time_d;
	logic [TIME_W-1:0]     elapsed;
	logic                  settling;
	logic                  emit;
	logic                  released;
	logic                  pending_d;

	// Debounce time register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q <= DEBOUNCE_RESET;
		end else if (cfg_wr_en) begin
			debounce_q <= cfg_wr_data;
		end
	end

	// Debounce decision; the event sets pending before the same poll is scanned.
	always_comb begin
		pend_eff      = pending_q | int_event;
		changed       = key != raw_key_q;
		change_time_d = changed ? now_ms : change_time_q;
		elapsed       = now_ms - change_time_d;
		settling      = elapsed < {{(TIME_W-DEBOUNCE_W){1'b0}}, debounce_q};
		emit          = pend_eff && key != NO_KEY && !settling && key != stable_key_q;
		released      = pend_eff && key == NO_KEY && !settling;
		pending_d     = pend_eff && !(released && int_level);
		result.key_char     = emit ? key : NO_KEY;
		result.scan_pending = pending_d;
	end

	// Scanner state, updated when a transaction moves into the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q     <= 1'b0;
			raw_key_q     <= NO_KEY;
			change_time_q <= '0;
			stable_key_q  <= NO_KEY;
		end else if (fire) begin
			pending_q <= pending_d;
			if (pend_eff) begin
				raw_key_q     <= key;
				change_time_q <= change_time_d;
			end
			if (emit) begin
				stable_key_q <= key;
			end else if (released) begin
				stable_key_q <= NO_KEY;
			end
		end
	end

	// An emitted key always leaves the scanner pending.
	a_emit_keeps_pending: assert property (@(posedge clk) disable iff (!arst_n)
		fire && emit |=> pending_q && stable_key_q == $past(key))
		else $error("emitted key did not become the stable key");

	// With nothing pending and no event, the key state does not move.
	a_idle_no_change: assert property (@(posedge clk) disable iff (!arst_n)
		fire && !pending_q && !int_event |=> !pending_q && $stable(raw_key_q)
		&& $stable(stable_key_q))
		else $error("state changed while not pending");

endmodule : kpd_debounce
`default_nettype wire
